FILE: sv/hlm_pkg.sv
package hlm_pkg;

  // table size and per-tick result cap
  localparam int SLOTS      = 8;
  localparam int RESULT_CAP = 8;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(RESULT_CAP + 1);
  localparam int PROD_W = 48;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 1'd1;

  localparam logic [15:0] TICK_PERIOD_RST     = 16'd100;
  localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd5000;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_REG   = 2'd1;
  localparam logic [1:0] REQ_UNREG = 2'd2;
  localparam logic [1:0] REQ_HB    = 2'd3;

  // result kinds and codes
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_DUP      = 2'd1;
  localparam logic [1:0] RES_FULL     = 2'd2;
  localparam logic [1:0] RES_NOTFOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              start;  // latch request, bump tick counter on a tick
    logic              srch;   // id / free-slot search step at idx
    logic              reply;  // apply request and load reply beat
    logic              mul;    // elapsed * period into product register
    logic              cmp;    // compare product, record change bit at idx
    logic              emit;   // load event beat for idx, flip its flag
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic emit_pend;  // slot idx has a change to report
  } stat_t;

endpackage

FILE: sv/hlm_ctrl.sv
module hlm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  output logic                in_stall,
  input  hlm_pkg::stat_t      stat,
  output hlm_pkg::cmd_t       cmd
);
  import hlm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRCH  = 3'd1;
  localparam logic [2:0] ST_REPLY = 3'd2;
  localparam logic [2:0] ST_TMUL  = 3'd3;
  localparam logic [2:0] ST_TCMP  = 3'd4;
  localparam logic [2:0] ST_TEMIT = 3'd5;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] idx, idx_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          idx_next   = '0;
          state_next = (req_type == REQ_TICK) ? ST_TMUL : ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd.srch = 1'b1;
        if (idx == SLOT_LAST) begin
          state_next = ST_REPLY;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_REPLY: begin
        if (stat.out_free) begin
          cmd.reply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_TCMP;
      end
      ST_TCMP: begin
        cmd.cmp = 1'b1;
        if (idx == SLOT_LAST) begin
          idx_next   = '0;
          state_next = ST_TEMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_TMUL;
        end
      end
      ST_TEMIT: begin
        // wait only when there is something to send and no room
        if (!stat.emit_pend || stat.out_free) begin
          cmd.emit = stat.emit_pend;
          if (idx == SLOT_LAST) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

FILE: sv/hlm_datapath.sv
module hlm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [1:0]                    req_type,
  input  logic [31:0]                   dev_id,
  input  logic [31:0]                   dev_timeout,
  input  hlm_pkg::cmd_t                 cmd,
  output hlm_pkg::stat_t                stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          kind,
  output logic [1:0]                    code,
  output logic [31:0]                   dev_id_res,
  output logic                          online,
  output logic                          last
);
  import hlm_pkg::*;

  // configuration
  logic [15:0] tick_period;
  logic [31:0] default_timeout;

  // latched request
  logic [1:0]  req_type_r;
  logic [31:0] req_id;
  logic [31:0] req_tmo;

  // slot table
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] online_f;
  logic [31:0]      slot_id   [SLOTS];
  logic [31:0]      slot_tmo  [SLOTS];
  logic [31:0]      slot_seen [SLOTS];
  logic [31:0]      tick_count;

  // search results
  logic              found, free_found;
  logic [SLOT_W-1:0] match_idx, free_idx;

  // tick scan
  logic [PROD_W-1:0] prod;
  logic [SLOTS-1:0]  chg;
  logic [CNT_W-1:0]  cnt;

  logic [31:0]      elapsed;
  logic             now_online;
  logic [SLOTS-1:0] above;
  logic             emit_last;
  logic [1:0]       reply_code;
  logic             do_reg, do_unreg, do_hb;
  logic             load;

  assign elapsed    = tick_count - slot_seen[cmd.idx];
  assign now_online = !(prod >= {16'd0, slot_tmo[cmd.idx]});

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (j > int'(cmd.idx));
    end
  end

  assign emit_last = (cnt == CNT_W'(RESULT_CAP - 1)) || ((chg & above) == '0);

  always_comb begin
    reply_code = RES_OK;
    case (req_type_r)
      REQ_REG: begin
        if (found) begin
          reply_code = RES_DUP;
        end else if (!free_found) begin
          reply_code = RES_FULL;
        end
      end
      REQ_UNREG, REQ_HB: begin
        if (!found) begin
          reply_code = RES_NOTFOUND;
        end
      end
      default: reply_code = RES_OK;
    endcase
  end

  assign do_reg   = cmd.reply && (req_type_r == REQ_REG) && !found && free_found;
  assign do_unreg = cmd.reply && (req_type_r == REQ_UNREG) && found;
  assign do_hb    = cmd.reply && (req_type_r == REQ_HB) && found;

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.emit_pend = chg[cmd.idx] && (cnt < CNT_W'(RESULT_CAP));

  assign load = cmd.reply || cmd.emit;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period     <= TICK_PERIOD_RST;
      default_timeout <= DEFAULT_TIMEOUT_RST;
      tick_count      <= '0;
      used            <= '0;
      online_f        <= '0;
      found           <= 1'b0;
      free_found      <= 1'b0;
      cnt             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_PERIOD:     tick_period     <= cfg_data[15:0];
          CFG_DEFAULT_TIMEOUT: default_timeout <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        found      <= 1'b0;
        free_found <= 1'b0;
        cnt        <= '0;
        if (req_type == REQ_TICK) begin
          tick_count <= tick_count + 32'd1;
        end
      end
      if (cmd.srch) begin
        if (used[cmd.idx] && (slot_id[cmd.idx] == req_id) && !found) begin
          found <= 1'b1;
        end
        if (!used[cmd.idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (do_reg) begin
        used[free_idx]     <= 1'b1;
        online_f[free_idx] <= 1'b1;
      end
      if (do_unreg) begin
        used[match_idx]     <= 1'b0;
        online_f[match_idx] <= 1'b0;
      end
      if (cmd.emit) begin
        online_f[cmd.idx] <= ~online_f[cmd.idx];
        cnt               <= cnt + 1'b1;
      end
      // a load only comes when the register is free or drains this cycle
      out_valid <= load || (out_valid && out_stall);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type_r <= req_type;
      req_id     <= dev_id;
      req_tmo    <= dev_timeout;
    end
    if (cmd.srch) begin
      if (used[cmd.idx] && (slot_id[cmd.idx] == req_id) && !found) begin
        match_idx <= cmd.idx;
      end
      if (!used[cmd.idx] && !free_found) begin
        free_idx <= cmd.idx;
      end
    end
    if (do_reg) begin
      slot_id[free_idx]   <= req_id;
      slot_tmo[free_idx]  <= (req_tmo != 32'd0) ? req_tmo : default_timeout;
      slot_seen[free_idx] <= tick_count;
    end
    if (do_hb) begin
      slot_seen[match_idx] <= tick_count;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(elapsed) * PROD_W'(tick_period);
    end
    if (cmd.cmp) begin
      chg[cmd.idx] <= used[cmd.idx] && (now_online != online_f[cmd.idx]);
    end
    if (cmd.reply) begin
      kind       <= KIND_REPLY;
      code       <= reply_code;
      dev_id_res <= req_id;
      online     <= 1'b0;
      last       <= 1'b1;
    end else if (cmd.emit) begin
      kind       <= KIND_EVENT;
      code       <= RES_OK;
      dev_id_res <= slot_id[cmd.idx];
      online     <= ~online_f[cmd.idx];
      last       <= emit_last;
    end
  end

endmodule

FILE: sv/heartbeat_liveness_monitor.sv
// Channel   Dir  Handshake             Payload
// input     in   in_valid / in_stall   req_type, dev_id, dev_timeout
// output    out  out_valid / out_stall kind, code, dev_id_res, online, last
// config    in   cfg_we                cfg_index, cfg_data
//
// Register, unregister, heartbeat: the id and free-slot search steps one slot
// per cycle, then the reply beat is loaded.
// Tick: a multiply and a compare step per slot, then one slot per cycle to send
// changes, unless an output stall holds the scan.
// Reset (rst, synchronous) empties the table, zeroes the tick counter and
// loads period 100 ms, default timeout 5000 ms; no clearing pass.
// A result beat waits in the output register under out_stall; the scan
// holds only when it has a new beat and that register is still full.
module heartbeat_liveness_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [31:0]                   dev_id,
  input  logic [31:0]                   dev_timeout,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [1:0]                    code,
  output logic [31:0]                   dev_id_res,
  output logic                          online,
  output logic                          last
);
  import hlm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: accept, search / scan steps, beat issue
  hlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table, tick counter, config, multiplier and output register
  hlm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .dev_id      (dev_id),
    .dev_timeout (dev_timeout),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .kind        (kind),
    .code        (code),
    .dev_id_res  (dev_id_res),
    .online      (online),
    .last        (last)
  );

endmodule

FILE: sv/hlm_checker.sv
module hlm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [1:0] code,
  input logic       online,
  input logic       last
);
  import hlm_pkg::*;

  // a stalled beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a reply is always the only and final beat, with online low
  a_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REPLY) |-> last && !online)
    else $error("malformed reply beat");

  // events carry ok
  a_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EVENT) |-> (code == RES_OK))
    else $error("event with nonzero code");

endmodule

bind heartbeat_liveness_monitor hlm_checker u_hlm_checker (.*);

FILE: bench/heartbeat_liveness_monitor_tb.sv
module heartbeat_liveness_monitor_tb;
  import hlm_pkg::*;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic        kind;
    logic [1:0]  code;
    logic [31:0] dev;
    logic        online;
    logic        last;
  } status_beat_t;

  // Shadow of the device table plus the queue of beats it predicts.
  // note_request() runs on every accepted input beat, check() on every output beat.
  class liveness_scoreboard;
    logic [15:0]  period;
    logic [31:0]  dflt_tmo;
    logic [31:0]  ticks;
    logic         used[SLOTS];
    logic [31:0]  ids[SLOTS];
    logic [31:0]  tmo_of[SLOTS];
    logic [31:0]  seen[SLOTS];
    logic         is_online[SLOTS];
    status_beat_t expected_beats[$];
    int           failures;

    function new();
      period   = TICK_PERIOD_RST;
      dflt_tmo = DEFAULT_TIMEOUT_RST;
      ticks    = '0;
      failures = 0;
      for (int i = 0; i < SLOTS; i++) begin
        used[i]      = 1'b0;
        ids[i]       = '0;
        tmo_of[i]    = '0;
        seen[i]      = '0;
        is_online[i] = 1'b0;
      end
    endfunction

    function void set_config(logic [15:0] p, logic [31:0] d);
      period   = p;
      dflt_tmo = d;
    endfunction

    // Tick: bump the counter, then walk the slots in order. Product is kept
    // at 48 bits so a large period times a large gap never wraps.
    function void advance_tick();
      logic [31:0]  elapsed;
      logic [47:0]  ms;
      logic         now_on;
      int           n;
      status_beat_t b;
      n = 0;
      ticks = ticks + 32'd1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[i]) continue;
        elapsed = ticks - seen[i];
        ms      = {16'd0, elapsed} * {32'd0, period};
        now_on  = (ms >= {16'd0, tmo_of[i]}) ? 1'b0 : 1'b1;
        if (now_on != is_online[i] && n < RESULT_CAP) begin
          is_online[i] = now_on;
          b = '{KIND_EVENT, RES_OK, ids[i], now_on, 1'b0};
          expected_beats.push_back(b);
          n++;
        end
      end
      if (n > 0) begin
        b = expected_beats.pop_back();
        b.last = 1'b1;
        expected_beats.push_back(b);
      end
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] id, logic [31:0] tmo);
      int           hit;
      logic [1:0]   rc;
      status_beat_t b;
      if (req == REQ_TICK) begin
        advance_tick();
        return;
      end
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && used[i] && ids[i] == id) hit = i;
      rc = RES_OK;
      case (req)
        REQ_REG: begin
          if (hit >= 0) begin
            rc = RES_DUP;
          end else begin
            rc = RES_FULL;
            for (int i = 0; i < SLOTS; i++) begin
              if (rc == RES_FULL && !used[i]) begin
                used[i]      = 1'b1;
                ids[i]       = id;
                tmo_of[i]    = (tmo != 0) ? tmo : dflt_tmo;
                seen[i]      = ticks;
                is_online[i] = 1'b1;
                rc           = RES_OK;
              end
            end
          end
        end
        REQ_UNREG: begin
          if (hit < 0) begin
            rc = RES_NOTFOUND;
          end else begin
            used[hit]      = 1'b0;
            ids[hit]       = '0;
            tmo_of[hit]    = '0;
            seen[hit]      = '0;
            is_online[hit] = 1'b0;
          end
        end
        default: begin
          if (hit < 0) rc = RES_NOTFOUND;
          else seen[hit] = ticks;
        end
      endcase
      b = '{KIND_REPLY, rc, id, 1'b0, 1'b1};
      expected_beats.push_back(b);
    endfunction

    function void check(status_beat_t got);
      status_beat_t want;
      if (expected_beats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: kind=%0d code=%0d id=%h online=%0d last=%0d",
                   got.kind, got.code, got.dev, got.online, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind || got.code !== want.code || got.dev !== want.dev ||
          got.online !== want.online || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: exp kind=%0d code=%0d id=%h online=%0d last=%0d",
                   want.kind, want.code, want.dev, want.online, want.last);
          $display("          got kind=%0d code=%0d id=%h online=%0d last=%0d",
                   got.kind, got.code, got.dev, got.online, got.last);
        end
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
  localparam int SETTLE      = 40;    // longer than one full tick scan
  localparam int LONG_HOLD   = 300;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type    = REQ_TICK;
  logic [31:0] dev_id      = '0;
  logic [31:0] dev_timeout = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        kind;
  logic [1:0]  code;
  logic [31:0] dev_id_res;
  logic        online;
  logic        last;

  liveness_scoreboard sb;
  status_beat_t       out_beat;
  logic [31:0]        id_pool[12];
  bit                 calm      = 1'b0;  // no idling on either side while set
  bit                 hold_req  = 1'b0;  // asks the receiver for one long hold
  int                 stall_left = 0;
  int                 quiet      = 0;

  heartbeat_liveness_monitor i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .dev_id      (dev_id),
    .dev_timeout (dev_timeout),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .code        (code),
    .dev_id_res  (dev_id_res),
    .online      (online),
    .last        (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: after each beat draw a random stall, unless calm. A hold request
  // turns into a long stall counted here, so the block backs up into in_stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_beat = '{kind, code, dev_id_res, online, last};
        sb.check(out_beat);
        stall_left = calm ? 0 : $urandom_range(0, 5);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hang shows up as a long run with no beat moving anywhere.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("heartbeat_liveness_monitor_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one request beat after a random gap; predict it once accepted.
  // valid stays high on return, so a back-to-back beat follows with no gap.
  task automatic send_req(input logic [1:0] req, input logic [31:0] id,
                          input logic [31:0] tmo);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    dev_id      <= id;
    dev_timeout <= tmo;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, id, tmo);
  endtask

  // Sender pause: everything out, then long enough for a quiet tick scan.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  // Upper data bits on the period write are junk the block must ignore.
  task automatic load_config(input logic [15:0] p, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK_PERIOD;
    cfg_data  <= {16'($urandom), p};
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_TIMEOUT;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(p, d);
  endtask

  // Unregister whatever the shadow table holds.
  task automatic clear_table();
    logic [31:0] gone[$];
    for (int i = 0; i < SLOTS; i++)
      if (sb.used[i]) gone.push_back(sb.ids[i]);
    foreach (gone[k]) send_req(REQ_UNREG, gone[k], $urandom);
  endtask

  // Mostly well-formed traffic on a small id pool, timeouts a few periods
  // long so devices really time out; a slice of pure noise on top.
  task automatic send_random(input logic [15:0] p);
    int          pick;
    logic [1:0]  req;
    logic [31:0] id;
    logic [31:0] tmo;
    pick = $urandom_range(0, 99);
    id   = id_pool[$urandom_range(0, 11)];
    case ($urandom_range(0, 7))
      0:       tmo = '0;
      1:       tmo = $urandom;
      default: tmo = {16'd0, p} * 32'($urandom_range(0, 5)) + 32'($urandom_range(0, 2));
    endcase
    if (pick < 40)      req = REQ_TICK;
    else if (pick < 62) req = REQ_REG;
    else if (pick < 74) req = REQ_UNREG;
    else                req = REQ_HB;
    if (pick >= 95) begin
      req = 2'($urandom);
      id  = $urandom;
    end
    if (req == REQ_TICK) begin
      id  = $urandom;
      tmo = $urandom;
    end
    send_req(req, id, tmo);
  endtask

  task automatic run_phase(input logic [15:0] p, input logic [31:0] d,
                           input bit quiet_sides, input bit long_hold);
    drain();
    load_config(p, d);
    calm = quiet_sides;
    if (long_hold) hold_req = 1'b1;
    repeat (45) send_random(p);
  endtask

  initial begin
    logic [15:0] mid_p;
    sb = new();
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'hAAAA_AAAA;
    id_pool[3] = 32'h5555_5555;
    for (int i = 4; i < 12; i++) id_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset config (100 ms per tick, 5000 ms default).
    send_req(REQ_TICK,  32'd0,        32'd0);          // quiet tick, empty table
    send_req(REQ_REG,   32'h0,        32'h0);          // default timeout
    send_req(REQ_REG,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_REG,   32'h0,        32'd7);          // duplicate id
    send_req(REQ_REG,   32'd5,        32'd100);        // offline after one tick
    send_req(REQ_REG,   32'd6,        32'd150);        // offline after two
    send_req(REQ_HB,    32'h1234_5678, 32'd0);         // unknown heartbeat
    send_req(REQ_UNREG, 32'd77,       32'd0);          // unknown unregister
    send_req(REQ_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_TICK,  32'd0,        32'd0);
    send_req(REQ_HB,    32'd6,        32'd0);
    send_req(REQ_TICK,  32'd0,        32'd0);          // 6 comes back online
    send_req(REQ_REG,   32'hAAAA_AAAA, 32'h5555_5555);
    send_req(REQ_REG,   32'h5555_5555, 32'hAAAA_AAAA);
    send_req(REQ_REG,   32'd8,        32'd1000);
    send_req(REQ_REG,   32'd9,        32'd300);        // table now full
    send_req(REQ_REG,   32'd10,       32'd400);        // no free slot
    send_req(REQ_UNREG, 32'd5,        32'd0);
    send_req(REQ_REG,   32'd11,       32'd1);          // reuses freed slot
    send_req(REQ_TICK,  32'd0,        32'd0);
    send_req(REQ_HB,    32'hFFFF_FFFF, 32'd0);
    send_req(REQ_UNREG, 32'h0,        32'd0);

    run_phase(16'd1,     32'd1,         1'b1, 1'b0);   // smallest, no idling
    run_phase(16'd65535, 32'hFFFF_FFFF, 1'b0, 1'b1);   // largest, long hold

    // Zero period and zero default: a full table of zero-timeout devices
    // all drop on one tick, the most beats one item can cause.
    drain();
    load_config(16'd0, 32'd0);
    calm = 1'b0;
    clear_table();
    for (int i = 0; i < SLOTS; i++) send_req(REQ_REG, 32'd100 + i, 32'd0);
    send_req(REQ_TICK, 32'd0, 32'd0);
    clear_table();
    repeat (45) send_random(16'd0);

    mid_p = 16'($urandom_range(2, 500));
    run_phase(mid_p, 32'($urandom_range(1, 3000)), 1'b0, 1'b0);
    run_phase(TICK_PERIOD_RST, DEFAULT_TIMEOUT_RST, 1'b0, 1'b0);

    drain();
    if (sb.failures == 0 && sb.expected_beats.size() == 0)
      $display("heartbeat_liveness_monitor_tb OK");
    else
      $display("heartbeat_liveness_monitor_tb NOT OK");
    $finish;
  end

endmodule
